// File: src/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int FOUND_W = 4;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 5;

    typedef enum logic [KIND_W-1:0] {
        K_INSERT,
        K_REMOVE,
        K_READ,
        K_WRITE,
        K_FIND,
        K_MIN,
        K_MAX,
        K_CLEAR
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        S_OK,
        S_EMPTY,
        S_FULL,
        S_RANGE,
        S_NOTFOUND
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_op;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: src/pls_if.sv
`timescale 1ns / 1ps

interface pls_req_if;
    logic                              valid;
    logic                              ready;
    logic [pls_pkg::KIND_W-1:0]        kind;
    logic [pls_pkg::POS_W-1:0]         position;
    logic signed [pls_pkg::VAL_W-1:0]  item_value;

    modport source (output valid, kind, position, item_value, input ready);
    modport sink   (input valid, kind, position, item_value, output ready);
endinterface

interface pls_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [pls_pkg::VAL_W-1:0]  result_value;
    logic [pls_pkg::FOUND_W-1:0]       found_position;
    logic [pls_pkg::STAT_W-1:0]        status;
    logic [pls_pkg::CNT_W-1:0]         count;

    modport source (output valid, result_value, found_position, status, count, input ready);
    modport sink   (input valid, result_value, found_position, status, count, output ready);
endinterface

// File: src/positional_list_store_top.sv
`timescale 1ns / 1ps
// positional list store: bounded ordered list of signed 32-bit values
// i_req carries one request (kind, position, item_value); o_rsp returns
// exactly one response per request (result_value, found_position, status,
// count), in request order, both with valid/ready handshakes.
// requests are handled one at a time. each request is captured, checked
// and, for find, minimum and maximum on a nonempty list, walked one entry
// per cycle through a single compare unit before its response is loaded
// into the output register. ready for the next request is raised in the
// cycle after the response is loaded.
// insert and remove shift the entries from the target position up together through the cell chain.
// the response sits in an output register; while the receiver stalls it
// holds, the block may take and work on one more request, and that one
// waits at its final step until the output register is free.
// synchronous reset empties the list and drops any pending response; cell
// contents are not cleared since entries above the count are never shown.
module positional_list_store_top #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pls_req_if.sink   i_req,
    pls_rsp_if.source o_rsp
);
    import pls_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pls_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pls_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_kind           (i_req.kind),
        .i_position       (i_req.position),
        .i_item_value     (i_req.item_value),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_result_value   (o_rsp.result_value),
        .o_found_position (o_rsp.found_position),
        .o_status         (o_rsp.status),
        .o_count          (o_rsp.count)
    );

endmodule

// File: src/pls_ctrl.sv
`timescale 1ns / 1ps

module pls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  pls_pkg::t_dp_stat i_stat,
    output pls_pkg::t_dp_cmd  o_cmd
);
    import pls_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_stat.scan_op ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
                if (i_stat.scan_last) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready     = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            ST_CHECK: ;
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: src/pls_dp.sv
`timescale 1ns / 1ps

module pls_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pls_pkg::t_dp_cmd                  i_cmd,
    output pls_pkg::t_dp_stat                 o_stat,
    input  logic [pls_pkg::KIND_W-1:0]        i_kind,
    input  logic [pls_pkg::POS_W-1:0]         i_position,
    input  logic signed [pls_pkg::VAL_W-1:0]  i_item_value,
    output logic                              o_rsp_valid,
    input  logic                              i_rsp_ready,
    output logic signed [pls_pkg::VAL_W-1:0]  o_result_value,
    output logic [pls_pkg::FOUND_W-1:0]       o_found_position,
    output logic [pls_pkg::STAT_W-1:0]        o_status,
    output logic [pls_pkg::CNT_W-1:0]         o_count
);
    import pls_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // request held for the whole operation
    t_kind                    r_kind;
    logic [POS_W-1:0]         r_pos;
    logic signed [VAL_W-1:0]  r_val;

    logic [CW-1:0]            r_count;
    logic signed [VAL_W-1:0]  r_cell [CAPACITY];

    // scan state for find, minimum and maximum
    logic [IW-1:0]            r_idx;
    logic signed [VAL_W-1:0]  r_acc;
    logic                     r_hit;
    logic [IW-1:0]            r_hit_idx;

    logic                     r_out_valid;
    logic signed [VAL_W-1:0]  r_out_result;
    logic [FOUND_W-1:0]       r_out_found;
    t_status                  r_out_status;
    logic [CNT_W-1:0]         r_out_count;

    logic [PW-1:0]            pos_w;
    logic [PW-1:0]            cnt_w;
    logic [PW-1:0]            tgt;
    logic                     in_range;
    logic                     is_empty;
    logic                     is_full;
    logic                     ins_ok;
    logic                     rem_ok;
    logic                     wr_ok;
    logic signed [VAL_W-1:0]  rd_val;
    logic signed [VAL_W-1:0]  scan_elem;
    logic                     take;

    logic signed [VAL_W-1:0]  n_result;
    logic [IW-1:0]            n_found;
    t_status                  n_status;
    logic [CW-1:0]            n_count;
    logic [PW-1:0]            n_count_w;
    logic [PW-1:0]            n_found_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_kind);
            r_pos  <= i_position;
            r_val  <= i_item_value;
        end
    end

    assign pos_w    = PW'(r_pos);
    assign cnt_w    = PW'(r_count);
    assign in_range = pos_w < cnt_w;
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= CAP_C);
    // insert past the end appends
    assign tgt      = (r_kind == K_INSERT && pos_w > cnt_w) ? cnt_w : pos_w;
    assign ins_ok   = (r_kind == K_INSERT) && !is_full;
    assign rem_ok   = (r_kind == K_REMOVE) && !is_empty && in_range;
    assign wr_ok    = (r_kind == K_WRITE) && !is_empty && in_range;
    assign rd_val   = r_cell[tgt[IW-1:0]];

    assign scan_elem = r_cell[r_idx];
    assign take      = (r_kind == K_MIN) ? (scan_elem < r_acc) : (scan_elem > r_acc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx <= '0;
            r_hit <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_idx <= r_idx + IW'(1);
            if (r_idx == '0 || take) r_acc <= scan_elem;
            if (!r_hit && scan_elem == r_val) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
        end
    end

    assign o_stat.scan_op   = (r_kind == K_FIND || r_kind == K_MIN || r_kind == K_MAX)
                              && !is_empty;
    assign o_stat.scan_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_stat.out_free  = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_result = '0;
        n_found  = '0;
        n_status = S_OK;
        n_count  = r_count;
        if (r_kind == K_INSERT) begin
            if (is_full) n_status = S_FULL;
            else         n_count  = r_count + CW'(1);
        end else if (r_kind == K_CLEAR) begin
            n_count = '0;
        end else if (is_empty) begin
            n_status = S_EMPTY;
        end else begin
            case (r_kind)
                K_REMOVE, K_READ, K_WRITE: begin
                    if (!in_range) begin
                        n_status = S_RANGE;
                    end else if (r_kind != K_WRITE) begin
                        n_result = rd_val;
                        if (r_kind == K_REMOVE) n_count = r_count - CW'(1);
                    end
                end
                K_FIND: begin
                    if (r_hit) n_found  = r_hit_idx;
                    else       n_status = S_NOTFOUND;
                end
                K_MIN, K_MAX: begin
                    n_result = r_acc;
                end
                default: ;
            endcase
        end
    end

    assign n_count_w = PW'(n_count);
    assign n_found_w = PW'(n_found);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    // each cell takes from its neighbor below on insert, above on remove
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [PW-1:0] GP = PW'(g);
        logic signed [VAL_W-1:0] w_lower;
        logic signed [VAL_W-1:0] w_upper;

        if (g == 0) begin : g_first
            assign w_lower = r_val;
        end else begin : g_mid_lo
            assign w_lower = r_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_upper = r_cell[g];
        end else begin : g_mid_hi
            assign w_upper = r_cell[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.commit) begin
                if (ins_ok && GP > tgt) begin
                    r_cell[g] <= w_lower;
                end else if ((ins_ok || wr_ok) && GP == tgt) begin
                    r_cell[g] <= r_val;
                end else if (rem_ok && GP >= tgt) begin
                    r_cell[g] <= w_upper;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_result <= n_result;
            r_out_found  <= n_found_w[FOUND_W-1:0];
            r_out_status <= n_status;
            r_out_count  <= n_count_w[CNT_W-1:0];
        end
    end

    assign o_rsp_valid      = r_out_valid;
    assign o_result_value   = r_out_result;
    assign o_found_position = r_out_found;
    assign o_status         = r_out_status;
    assign o_count          = r_out_count;

endmodule

// File: src/pls_chk.sv
`timescale 1ns / 1ps

module pls_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_rsp_valid,
    input logic                              i_rsp_ready,
    input logic signed [pls_pkg::VAL_W-1:0]  i_result_value,
    input logic [pls_pkg::FOUND_W-1:0]       i_found_position,
    input logic [pls_pkg::STAT_W-1:0]        i_status,
    input logic [pls_pkg::CNT_W-1:0]         i_count
);
    import pls_pkg::*;

    // one request in flight: no accept in the cycle right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while previous one in flight");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_status) && $stable(i_count)
            && $stable(i_result_value) && $stable(i_found_position))
        else $error("stalled response changed");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == S_OK || i_status == S_EMPTY || i_status == S_FULL
                         || i_status == S_RANGE || i_status == S_NOTFOUND))
        else $error("illegal status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != S_OK |-> i_result_value == '0 && i_found_position == '0)
        else $error("error response carries data");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == S_EMPTY |-> i_count == '0)
        else $error("empty status with nonzero count");

endmodule

bind positional_list_store_top pls_chk u_pls_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_result_value   (o_rsp.result_value),
    .i_found_position (o_rsp.found_position),
    .i_status         (o_rsp.status),
    .i_count          (o_rsp.count)
);

// File: tb/list_response_checker.sv
`timescale 1ns / 1ps

module list_response_checker #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pls_req_if   i_req_mon,
    pls_rsp_if   i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import pls_pkg::*;

    typedef struct {
        logic signed [VAL_W-1:0] data;
        logic [FOUND_W-1:0]      found;
        t_status                 status;
        logic [CNT_W-1:0]        count;
    } t_list_response;

    // shadow copy of the list contents and its length
    logic signed [VAL_W-1:0] list_shadow [CAPACITY];
    int unsigned             shadow_count = 0;

    t_list_response expected_responses[$];
    t_list_response oldest_expected;
    int             mismatch_total = 0;

    function automatic t_list_response apply_list_request(
        t_kind                   kind,
        logic [POS_W-1:0]        pos,
        logic signed [VAL_W-1:0] item
    );
        t_list_response r;
        int unsigned    n;
        int unsigned    at;
        int unsigned    j;
        r.data   = '0;
        r.found  = '0;
        r.status = S_OK;
        n        = shadow_count;
        at       = pos;
        case (kind)
            K_INSERT: begin
                if (n >= CAPACITY) begin
                    r.status = S_FULL;
                end else begin
                    // past the end means append
                    if (at > n) at = n;
                    for (j = n; j > at; j--) list_shadow[j] = list_shadow[j-1];
                    list_shadow[at] = item;
                    shadow_count    = n + 1;
                end
            end
            K_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
                if (n == 0) begin
                    r.status = S_EMPTY;
                end else if (kind inside {K_REMOVE, K_READ, K_WRITE}) begin
                    if (at >= n) begin
                        r.status = S_RANGE;
                    end else if (kind == K_REMOVE) begin
                        r.data = list_shadow[at];
                        for (j = at; j + 1 < n; j++) list_shadow[j] = list_shadow[j+1];
                        shadow_count = n - 1;
                    end else if (kind == K_READ) begin
                        r.data = list_shadow[at];
                    end else begin
                        list_shadow[at] = item;
                    end
                end else if (kind == K_FIND) begin
                    r.status = S_NOTFOUND;
                    for (j = 0; j < n; j++) begin
                        if (list_shadow[j] == item) begin
                            r.found  = j[FOUND_W-1:0];
                            r.status = S_OK;
                            break;
                        end
                    end
                end else begin
                    r.data = list_shadow[0];
                    for (j = 1; j < n; j++) begin
                        if (kind == K_MIN ? list_shadow[j] < r.data
                                          : list_shadow[j] > r.data)
                            r.data = list_shadow[j];
                    end
                end
            end
        endcase
        r.count = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_mon.valid && i_req_mon.ready)
                expected_responses.push_back(apply_list_request(t_kind'(i_req_mon.kind),
                    i_req_mon.position, i_req_mon.item_value));
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (expected_responses.size() == 0) begin
                    if (mismatch_total < 10)
                        $display("%0t: response with no request pending", $realtime);
                    mismatch_total++;
                end else begin
                    oldest_expected = expected_responses.pop_front();
                    if (i_rsp_mon.result_value !== oldest_expected.data
                        || i_rsp_mon.found_position !== oldest_expected.found
                        || i_rsp_mon.status !== oldest_expected.status
                        || i_rsp_mon.count !== oldest_expected.count) begin
                        if (mismatch_total < 10)
                            $display({"%0t: mismatch, expected value %0d pos %0d status %0d",
                                      " count %0d, got value %0d pos %0d status %0d count %0d"},
                                     $realtime, oldest_expected.data, oldest_expected.found,
                                     oldest_expected.status, oldest_expected.count,
                                     i_rsp_mon.result_value, i_rsp_mon.found_position,
                                     i_rsp_mon.status, i_rsp_mon.count);
                        mismatch_total++;
                    end
                end
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= expected_responses.size();
    end

endmodule

// File: tb/positional_list_store_top_tb.sv
`timescale 1ns / 1ps

module positional_list_store_top_tb;
    import pls_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int ITEMS_PER_PHASE = 560;

    localparam logic signed [VAL_W-1:0] VALUE_POOL [8] = '{
        32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1,
        32'sd1, 32'sd5, -32'sd5, 32'sh1234_5678
    };

    typedef enum int {
        GROW,
        SHRINK,
        CHURN
    } t_traffic_mode;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct  = 23;
    int   recv_stall_pct = 84;
    int   fail_count;
    int   pending_responses;

    pls_req_if req_ch ();
    pls_rsp_if rsp_ch ();

    positional_list_store_top #(
        .CAPACITY (LIST_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    list_response_checker #(
        .CAPACITY (LIST_DEPTH)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_responses)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // valid is only dropped during an idle gap, so back-to-back requests keep it high
    task automatic send_request(t_kind kind, logic [POS_W-1:0] pos,
                                logic signed [VAL_W-1:0] item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= kind;
        req_ch.position   <= pos;
        req_ch.item_value <= item;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0) return VALUE_POOL[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, LIST_DEPTH));
        return POS_W'($urandom_range(LIST_DEPTH + 1, 31));
    endfunction

    function automatic t_kind pick_kind(t_traffic_mode mode);
        int r;
        int ins_lim;
        int rem_lim;
        r       = $urandom_range(0, 99);
        ins_lim = (mode == GROW) ? 60 : (mode == SHRINK) ? 10 : 25;
        rem_lim = ins_lim + ((mode == GROW) ? 5 : (mode == SHRINK) ? 45 : 15);
        if (r < ins_lim) return K_INSERT;
        if (r < rem_lim) return K_REMOVE;
        if (r < rem_lim + 2) return K_CLEAR;
        return t_kind'($urandom_range(K_READ, K_MAX));
    endfunction

    task automatic run_random_traffic(int n_items);
        t_traffic_mode mode;
        int            r;
        mode = CHURN;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                r    = $urandom_range(0, 9);
                mode = (r < 4) ? GROW : (r < 7) ? SHRINK : CHURN;
            end
            send_request(pick_kind(mode), pick_position(), pick_value());
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.kind       <= K_CLEAR;
        req_ch.position   <= '0;
        req_ch.item_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every request kind but insert on an empty list
        send_request(K_REMOVE, 0, 0);
        send_request(K_READ, 0, 0);
        send_request(K_WRITE, 0, 5);
        send_request(K_FIND, 0, 0);
        send_request(K_MIN, 0, 0);
        send_request(K_MAX, 0, 0);
        send_request(K_CLEAR, 0, 0);
        // inserts, also past the end (appended), then every other request kind on that list
        send_request(K_INSERT, 31, 32'sh7fff_ffff);
        send_request(K_INSERT, 0, 32'sh8000_0000);
        send_request(K_INSERT, 1, -32'sd1);
        send_request(K_INSERT, 20, -32'sd1);
        send_request(K_FIND, 7, -32'sd1);
        send_request(K_FIND, 0, 32'sd12345);
        send_request(K_MIN, 0, 0);
        send_request(K_MAX, 0, 0);
        send_request(K_READ, 3, 0);
        send_request(K_READ, 4, 0);
        send_request(K_READ, 31, 0);
        send_request(K_WRITE, 2, 0);
        send_request(K_WRITE, 4, 7);
        send_request(K_REMOVE, 4, 0);
        send_request(K_REMOVE, 0, 0);
        send_request(K_REMOVE, 2, 0);
        send_request(K_CLEAR, 0, 0);
        send_request(K_READ, 0, 0);

        run_random_traffic(ITEMS_PER_PHASE);
        send_idle_pct  = 84;
        recv_stall_pct = 23;
        run_random_traffic(ITEMS_PER_PHASE);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_traffic(ITEMS_PER_PHASE);
        req_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending_responses != 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_responses == 0) begin
            $display("positional_list_store_top_tb passed");
        end else begin
            $display("positional_list_store_top_tb failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("positional_list_store_top_tb failed");
        $finish;
    end

endmodule

// File: sim.f
src/pls_pkg.sv
src/pls_if.sv
src/pls_ctrl.sv
src/pls_dp.sv
src/positional_list_store_top.sv
src/pls_chk.sv
tb/list_response_checker.sv
tb/positional_list_store_top_tb.sv
